@@ hdl/mcep_pkg.sv @@
// ----------------------------------------------------------------------------
// MIDI channel event parser package
// Shared types, event type codes and the parameter count decode.
// ----------------------------------------------------------------------------
package mcep_pkg;

  localparam logic [3:0] TYPE_NOTE_OFF   = 4'h8;
  localparam logic [3:0] TYPE_CTRL       = 4'hB;
  localparam logic [3:0] TYPE_PROGRAM    = 4'hC;
  localparam logic [3:0] TYPE_CHAN_PRESS = 4'hD;
  localparam logic [3:0] TYPE_PITCH_BEND = 4'hE;

  localparam int unsigned DeltaWidth = 28;

  typedef struct packed {
    logic [DeltaWidth-1:0] delta_time;
    logic [3:0]            event_type;
    logic [3:0]            channel;
    logic [7:0]            param_one;
    logic [7:0]            param_two;
    logic [1:0]            param_count;
    logic                  delta_overflow;
  } result_t;

  function automatic logic [1:0] params_needed(input logic [3:0] ev_type);
    logic [1:0] cnt;
    cnt = 2'd0;
    if ((ev_type >= TYPE_NOTE_OFF && ev_type <= TYPE_CTRL) ||
        ev_type == TYPE_PITCH_BEND) begin
      cnt = 2'd2;
    end else if (ev_type == TYPE_PROGRAM || ev_type == TYPE_CHAN_PRESS) begin
      cnt = 2'd1;
    end
    return cnt;
  endfunction

endpackage

@@ hdl/midi_channel_event_parser_core.sv @@
// ----------------------------------------------------------------------------
// MIDI channel event parser core
// Parses a track byte stream into channel events with delta times.
// ----------------------------------------------------------------------------
// Each accepted byte is registered, applied to the parse state and, if it
// completes an event, written to the result register; a byte can be accepted
// every cycle while the result side keeps up. The last byte of an event passes
// the input register and then the result register. A pending result only
// stalls input when it is not taken and the next byte completes another event.
module midi_channel_event_parser_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [27:0] out_delta_time,
  output logic [3:0]  out_event_type,
  output logic [3:0]  out_channel,
  output logic [7:0]  out_param_one,
  output logic [7:0]  out_param_two,
  output logic [1:0]  out_param_count,
  output logic        out_delta_overflow
);

  logic              held_valid;
  logic [7:0]        held_byte;
  logic              emit;
  logic              free;
  logic              step;
  mcep_pkg::result_t step_result;
  mcep_pkg::result_t out_result;

  assign step = held_valid && (!emit || free);

  mcep_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .consume      (step),
    .held_valid   (held_valid),
    .held_byte    (held_byte)
  );

  mcep_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .data_byte (held_byte),
    .emit      (emit),
    .result    (step_result)
  );

  mcep_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step && emit),
    .result_in  (step_result),
    .free       (free),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result_out (out_result)
  );

  assign out_delta_time     = out_result.delta_time;
  assign out_event_type     = out_result.event_type;
  assign out_channel        = out_result.channel;
  assign out_param_one      = out_result.param_one;
  assign out_param_two      = out_result.param_two;
  assign out_param_count    = out_result.param_count;
  assign out_delta_overflow = out_result.delta_overflow;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_param_count != 2'd3)
    else $error("param count out of range");

  a_absent_params_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_param_count == 2'd0) |-> (out_param_one == 8'd0 &&
                                                out_param_two == 8'd0))
    else $error("absent parameters not zero");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready && held_valid && emit))
    else $error("input stalled without a blocked result");

endmodule

@@ hdl/mcep_in_stage.sv @@
// ----------------------------------------------------------------------------
// MIDI channel event parser input stage
// Registers one incoming byte and holds it until the parser consumes it.
// ----------------------------------------------------------------------------
module mcep_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       consume,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;

  assign in_ready  = !valid_r || consume;
  assign valid_nxt = (in_valid && in_ready) || (valid_r && !consume);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_data_byte;
    end
  end

  assign held_valid = valid_r;
  assign held_byte  = byte_r;

endmodule

@@ hdl/mcep_parser.sv @@
// ----------------------------------------------------------------------------
// MIDI channel event parser step logic
// Holds the parse state and applies one byte per step.
// ----------------------------------------------------------------------------
module mcep_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          data_byte,
  output logic                emit,
  output mcep_pkg::result_t   result
);

  localparam logic [1:0] PH_DELTA  = 2'd0;
  localparam logic [1:0] PH_STATUS = 2'd1;
  localparam logic [1:0] PH_PARAM1 = 2'd2;
  localparam logic [1:0] PH_PARAM2 = 2'd3;

  logic [1:0]                      phase_r, phase_nxt;
  logic [mcep_pkg::DeltaWidth-1:0] acc_r, acc_nxt;
  logic [2:0]                      len_r, len_nxt;
  logic                            ovf_r, ovf_nxt;
  logic [3:0]                      type_r, type_nxt;
  logic [3:0]                      chan_r, chan_nxt;
  logic [7:0]                      p1_r, p1_nxt;
  logic [1:0]                      need_cur;
  logic [1:0]                      need_new;

  assign need_cur = mcep_pkg::params_needed(type_r);
  assign need_new = mcep_pkg::params_needed(data_byte[7:4]);

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    len_nxt   = len_r;
    ovf_nxt   = ovf_r;
    type_nxt  = type_r;
    chan_nxt  = chan_r;
    p1_nxt    = p1_r;
    emit      = 1'b0;
    result    = '0;
    result.delta_time     = acc_r;
    result.delta_overflow = ovf_r;
    result.event_type     = type_r;
    result.channel        = chan_r;
    unique case (phase_r)
      PH_DELTA: begin
        if (len_r >= 3'd4) begin
          ovf_nxt = 1'b1;
        end
        if (len_r != 3'd7) begin
          len_nxt = len_r + 3'd1;
        end
        acc_nxt = {acc_r[mcep_pkg::DeltaWidth-8:0], data_byte[6:0]};
        if (!data_byte[7]) begin
          phase_nxt = PH_STATUS;
        end
      end
      PH_STATUS: begin
        type_nxt          = data_byte[7:4];
        chan_nxt          = data_byte[3:0];
        result.event_type = data_byte[7:4];
        result.channel    = data_byte[3:0];
        if (need_new == 2'd0) begin
          emit = 1'b1;
        end else begin
          phase_nxt = PH_PARAM1;
        end
      end
      PH_PARAM1: begin
        if (need_cur == 2'd2) begin
          p1_nxt    = data_byte;
          phase_nxt = PH_PARAM2;
        end else begin
          emit               = 1'b1;
          result.param_one   = data_byte;
          result.param_count = 2'd1;
        end
      end
      PH_PARAM2: begin
        emit               = 1'b1;
        result.param_one   = p1_r;
        result.param_two   = data_byte;
        result.param_count = 2'd2;
      end
      default: begin
        phase_nxt = PH_DELTA;
      end
    endcase
    if (emit) begin
      phase_nxt = PH_DELTA;
      acc_nxt   = '0;
      len_nxt   = 3'd0;
      ovf_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_DELTA;
      acc_r   <= '0;
      len_r   <= 3'd0;
      ovf_r   <= 1'b0;
      type_r  <= 4'd0;
      chan_r  <= 4'd0;
      p1_r    <= 8'd0;
    end else if (step) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      len_r   <= len_nxt;
      ovf_r   <= ovf_nxt;
      type_r  <= type_nxt;
      chan_r  <= chan_nxt;
      p1_r    <= p1_nxt;
    end
  end

endmodule

@@ hdl/mcep_out_stage.sv @@
// ----------------------------------------------------------------------------
// MIDI channel event parser output stage
// Registers one event result and holds it until the transfer completes.
// ----------------------------------------------------------------------------
module mcep_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  mcep_pkg::result_t result_in,
  output logic              free,
  output logic              out_valid,
  input  logic              out_ready,
  output mcep_pkg::result_t result_out
);

  logic              valid_r;
  logic              valid_nxt;
  mcep_pkg::result_t data_r;

  assign free      = !valid_r || out_ready;
  assign valid_nxt = load || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result_in;
    end
  end

  assign out_valid  = valid_r;
  assign result_out = data_r;

endmodule
